// File: rtl/core/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared constants and types for the segment pair intersector.
// ----------------------------------------------------------------------------
package spi_pkg;

	// quotient bits kept by the divider: 32 result bits plus one overflow guard
	localparam int unsigned QBITS   = 33;
	localparam int unsigned PT_BITS = 32;

	typedef logic [1:0] orient_t;

	localparam orient_t ORI_COLL = 2'd0;
	localparam orient_t ORI_CW   = 2'd1;
	localparam orient_t ORI_CCW  = 2'd2;

endpackage

// File: rtl/core/spi_fixdiv.sv
// ----------------------------------------------------------------------------
// spi_fixdiv
// Pipelined restoring divider: trunc(num * 2^FRAC_BITS / den) on magnitudes,
// one quotient bit per stage, with an overflow flag for quotients >= 2^QBITS.
// ----------------------------------------------------------------------------
module spi_fixdiv #(
	parameter int NW        = 51,
	parameter int DW        = 35,
	parameter int FRAC_BITS = 8
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [NW-1:0]             num,
	input  logic [DW-1:0]             den,
	output logic [spi_pkg::QBITS-1:0] quo,
	output logic                      ovf
);
	import spi_pkg::*;

	localparam int TW = NW + FRAC_BITS;
	localparam int XW = TW + QBITS;
	localparam int MW = (TW > DW) ? TW : DW;
	localparam int RW = DW + 1;

	logic [XW-1:0]    nx;
	logic [TW-1:0]    top;
	logic             ovf0;

	logic [DW-1:0]    rem_s [0:QBITS];
	logic [QBITS-1:0] low_s [0:QBITS];
	logic [QBITS-1:0] quo_s [0:QBITS];
	logic [DW-1:0]    den_s [0:QBITS];
	logic             ovf_s [0:QBITS];

	assign nx   = XW'(num) << FRAC_BITS;
	assign top  = nx[XW-1:QBITS];
	assign ovf0 = MW'(top) >= MW'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(MW'(top));
			low_s[0] <= nx[QBITS-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= ovf0;
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge;

		assign trial = {rem_s[k-1], low_s[k-1][QBITS-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_s[k-1]}) : DW'(trial);
				low_s[k] <= {low_s[k-1][QBITS-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QBITS-2:0], ge};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[QBITS];
	assign ovf = ovf_s[QBITS];

endmodule

// File: rtl/core/segment_pair_intersector.sv
// ----------------------------------------------------------------------------
// segment_pair_intersector
// Closed segment touch test by orientation signs, plus the crossing point of
// the two lines in signed fixed point, truncated and saturated.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser
//  s_*     | in  | a_start_x .. b_end_y           | -
//  m_*     | out | point_x, point_y               | crosses, parallel, saturated
//
//  One pair is taken every cycle while m_* is not stalled; each result passes
//  six arithmetic stages, 34 divider stages and the output register.
//  Latency is set by the bit-per-stage quotient of the two line dividers.
//  Reset clears only the valid bits. A stall on m_* freezes the whole pipe.
// ----------------------------------------------------------------------------
module segment_pair_intersector #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [8*COORD_BITS-1:0]   s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// point_x, point_y
	output logic [63:0]               m_tdata,
	// crosses, parallel, saturated
	output logic [2:0]                m_tuser
);
	import spi_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int DFW = C + 1;
	localparam int PW  = 2 * C + 2;
	localparam int OW  = 2 * C + 3;
	localparam int DTW = 2 * C + 1;
	localparam int NPW = 3 * C + 2;
	localparam int NW  = 3 * C + 3;

	typedef logic signed [C-1:0]   crd_t;
	typedef logic signed [DFW-1:0] dif_t;
	typedef logic signed [PW-1:0]  prd_t;
	typedef logic signed [OW-1:0]  ori_v_t;
	typedef logic signed [DTW-1:0] det_t;
	typedef logic signed [NPW-1:0] npr_t;
	typedef logic signed [NW-1:0]  num_t;

	function automatic logic inbox(crd_t px, crd_t py, crd_t qx, crd_t qy,
			crd_t rx, crd_t ry);
		crd_t xlo, xhi, ylo, yhi;
		xlo = (px < rx) ? px : rx;
		xhi = (px < rx) ? rx : px;
		ylo = (py < ry) ? py : ry;
		yhi = (py < ry) ? ry : py;
		return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
	endfunction

	function automatic orient_t orient_of(ori_v_t v);
		orient_t o;
		if (v == '0)
			o = ORI_COLL;
		else if (v > 0)
			o = ORI_CW;
		else
			o = ORI_CCW;
		return o;
	endfunction

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- stage 1: coordinates
	logic v_s1;
	crd_t x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;

	// ---- stage 2: products and box tests
	logic v_s2;
	prd_t o1a_s2, o1b_s2, o2a_s2, o2b_s2, o3a_s2, o3b_s2, o4a_s2, o4b_s2;
	prd_t d1a_s2, d1b_s2, d2a_s2, d2b_s2, dna_s2, dnb_s2;
	dif_t dx12_s2, dy12_s2, dx34_s2, dy34_s2;
	logic [3:0] ib_s2;

	// ---- stage 3: orientations, determinants, denominator
	logic v_s3;
	orient_t o1_s3, o2_s3, o3_s3, o4_s3;
	det_t det1_s3, det2_s3;
	ori_v_t den_s3;
	dif_t dx12_s3, dy12_s3, dx34_s3, dy34_s3;
	logic [3:0] ib_s3;

	// ---- stage 4: numerator products, hit
	logic v_s4, hit_s4;
	npr_t xna_s4, xnb_s4, yna_s4, ynb_s4;
	ori_v_t den_s4;

	// ---- stage 5: numerators
	logic v_s5, hit_s5;
	num_t xn_s5, yn_s5;
	ori_v_t den_s5;

	// ---- stage 6: magnitudes and signs
	logic v_s6, hit_s6, par_s6, negx_s6, negy_s6;
	logic [NW-1:0] xmag_s6, ymag_s6;
	logic [OW-1:0] dmag_s6;

	// ---- divider side band
	logic dv_s   [0:QBITS];
	logic hit_ds [0:QBITS];
	logic par_ds [0:QBITS];
	logic negx_ds[0:QBITS];
	logic negy_ds[0:QBITS];

	logic [QBITS-1:0] qx, qy;
	logic ovfx, ovfy;

	logic out_vld_q, crosses_q, parallel_q, sat_q;
	logic [PT_BITS-1:0] ptx_q, pty_q;

	// ---- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_vld_q <= dv_s[QBITS];
		end
	end

	// ---- stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= s_tdata[0*C +: C];
			y1_s1 <= s_tdata[1*C +: C];
			x2_s1 <= s_tdata[2*C +: C];
			y2_s1 <= s_tdata[3*C +: C];
			x3_s1 <= s_tdata[4*C +: C];
			y3_s1 <= s_tdata[5*C +: C];
			x4_s1 <= s_tdata[6*C +: C];
			y4_s1 <= s_tdata[7*C +: C];
		end
	end

	// ---- stage 2
	dif_t ay21, ax32, ax21, ay32, ax42, ay42, ay43, ax14, ax43, ay14, ax24, ay24;
	assign ay21 = DFW'(y2_s1) - DFW'(y1_s1);
	assign ax21 = DFW'(x2_s1) - DFW'(x1_s1);
	assign ax32 = DFW'(x3_s1) - DFW'(x2_s1);
	assign ay32 = DFW'(y3_s1) - DFW'(y2_s1);
	assign ax42 = DFW'(x4_s1) - DFW'(x2_s1);
	assign ay42 = DFW'(y4_s1) - DFW'(y2_s1);
	assign ay43 = DFW'(y4_s1) - DFW'(y3_s1);
	assign ax43 = DFW'(x4_s1) - DFW'(x3_s1);
	assign ax14 = DFW'(x1_s1) - DFW'(x4_s1);
	assign ay14 = DFW'(y1_s1) - DFW'(y4_s1);
	assign ax24 = DFW'(x2_s1) - DFW'(x4_s1);
	assign ay24 = DFW'(y2_s1) - DFW'(y4_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			o1a_s2  <= PW'(ay21) * PW'(ax32);
			o1b_s2  <= PW'(ax21) * PW'(ay32);
			o2a_s2  <= PW'(ay21) * PW'(ax42);
			o2b_s2  <= PW'(ax21) * PW'(ay42);
			o3a_s2  <= PW'(ay43) * PW'(ax14);
			o3b_s2  <= PW'(ax43) * PW'(ay14);
			o4a_s2  <= PW'(ay43) * PW'(ax24);
			o4b_s2  <= PW'(ax43) * PW'(ay24);
			d1a_s2  <= PW'(x1_s1) * PW'(y2_s1);
			d1b_s2  <= PW'(y1_s1) * PW'(x2_s1);
			d2a_s2  <= PW'(x3_s1) * PW'(y4_s1);
			d2b_s2  <= PW'(y3_s1) * PW'(x4_s1);
			dna_s2  <= PW'(-ax21) * PW'(-ay43);
			dnb_s2  <= PW'(-ay21) * PW'(-ax43);
			dx12_s2 <= -ax21;
			dy12_s2 <= -ay21;
			dx34_s2 <= -ax43;
			dy34_s2 <= -ay43;
			ib_s2[0] <= inbox(x1_s1, y1_s1, x3_s1, y3_s1, x2_s1, y2_s1);
			ib_s2[1] <= inbox(x1_s1, y1_s1, x4_s1, y4_s1, x2_s1, y2_s1);
			ib_s2[2] <= inbox(x3_s1, y3_s1, x1_s1, y1_s1, x4_s1, y4_s1);
			ib_s2[3] <= inbox(x3_s1, y3_s1, x2_s1, y2_s1, x4_s1, y4_s1);
		end
	end

	// ---- stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			o1_s3   <= orient_of(OW'(o1a_s2) - OW'(o1b_s2));
			o2_s3   <= orient_of(OW'(o2a_s2) - OW'(o2b_s2));
			o3_s3   <= orient_of(OW'(o3a_s2) - OW'(o3b_s2));
			o4_s3   <= orient_of(OW'(o4a_s2) - OW'(o4b_s2));
			det1_s3 <= DTW'(d1a_s2 - d1b_s2);
			det2_s3 <= DTW'(d2a_s2 - d2b_s2);
			den_s3  <= OW'(dna_s2) - OW'(dnb_s2);
			dx12_s3 <= dx12_s2;
			dy12_s3 <= dy12_s2;
			dx34_s3 <= dx34_s2;
			dy34_s3 <= dy34_s2;
			ib_s3   <= ib_s2;
		end
	end

	// ---- stage 4
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= ((o1_s3 != o2_s3) && (o3_s3 != o4_s3))
				|| ((o1_s3 == ORI_COLL) && ib_s3[0])
				|| ((o2_s3 == ORI_COLL) && ib_s3[1])
				|| ((o3_s3 == ORI_COLL) && ib_s3[2])
				|| ((o4_s3 == ORI_COLL) && ib_s3[3]);
			xna_s4 <= NPW'(det1_s3) * NPW'(dx34_s3);
			xnb_s4 <= NPW'(dx12_s3) * NPW'(det2_s3);
			yna_s4 <= NPW'(det1_s3) * NPW'(dy34_s3);
			ynb_s4 <= NPW'(dy12_s3) * NPW'(det2_s3);
			den_s4 <= den_s3;
		end
	end

	// ---- stage 5
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5 <= hit_s4;
			xn_s5  <= NW'(xna_s4) - NW'(xnb_s4);
			yn_s5  <= NW'(yna_s4) - NW'(ynb_s4);
			den_s5 <= den_s4;
		end
	end

	// ---- stage 6
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6  <= hit_s5;
			par_s6  <= den_s5 == '0;
			negx_s6 <= xn_s5[NW-1] ^ den_s5[OW-1];
			negy_s6 <= yn_s5[NW-1] ^ den_s5[OW-1];
			xmag_s6 <= xn_s5[NW-1] ? NW'(-xn_s5) : NW'(xn_s5);
			ymag_s6 <= yn_s5[NW-1] ? NW'(-yn_s5) : NW'(yn_s5);
			dmag_s6 <= den_s5[OW-1] ? OW'(-den_s5) : OW'(den_s5);
		end
	end

	// ---- dividers
	spi_fixdiv #(.NW(NW), .DW(OW), .FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk    (clk),
		.en     (en),
		.num    (xmag_s6),
		.den    (dmag_s6),
		.quo    (qx),
		.ovf    (ovfx)
	);

	spi_fixdiv #(.NW(NW), .DW(OW), .FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk    (clk),
		.en     (en),
		.num    (ymag_s6),
		.den    (dmag_s6),
		.quo    (qy),
		.ovf    (ovfy)
	);

	// side band travels beside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QBITS; k++)
				dv_s[k] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= v_s6;
			for (int k = 1; k <= QBITS; k++)
				dv_s[k] <= dv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_ds[0]  <= hit_s6;
			par_ds[0]  <= par_s6;
			negx_ds[0] <= negx_s6;
			negy_ds[0] <= negy_s6;
			for (int k = 1; k <= QBITS; k++) begin
				hit_ds[k]  <= hit_ds[k-1];
				par_ds[k]  <= par_ds[k-1];
				negx_ds[k] <= negx_ds[k-1];
				negy_ds[k] <= negy_ds[k-1];
			end
		end
	end

	// ---- output: clamp, apply sign
	localparam logic [QBITS-1:0] LIM_POS = QBITS'(33'h0_7FFF_FFFF);
	localparam logic [QBITS-1:0] LIM_NEG = QBITS'(33'h0_8000_0000);

	logic [QBITS-1:0]   limx, limy;
	logic               satx, saty;
	logic [PT_BITS-1:0] magx, magy;

	assign limx = negx_ds[QBITS] ? LIM_NEG : LIM_POS;
	assign limy = negy_ds[QBITS] ? LIM_NEG : LIM_POS;
	assign satx = ovfx || (qx > limx);
	assign saty = ovfy || (qy > limy);
	assign magx = satx ? limx[PT_BITS-1:0] : qx[PT_BITS-1:0];
	assign magy = saty ? limy[PT_BITS-1:0] : qy[PT_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			crosses_q  <= hit_ds[QBITS];
			parallel_q <= par_ds[QBITS];
			sat_q      <= !par_ds[QBITS] && (satx || saty);
			if (par_ds[QBITS]) begin
				ptx_q <= '0;
				pty_q <= '0;
			end else begin
				ptx_q <= negx_ds[QBITS] ? -magx : magx;
				pty_q <= negy_ds[QBITS] ? -magy : magy;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {pty_q, ptx_q};
	assign m_tuser  = {sat_q, parallel_q, crosses_q};

`ifndef SYNTHESIS
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[2])
		else $error("parallel result carries a point or saturation");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |->
			(m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000)
			|| (m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000))
		else $error("saturated result without a clamped coordinate");

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv_s[QBITS] |=> m_tvalid)
		else $error("divider output lost at output register");

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted request not in stage 1");
`endif

endmodule

// File: dv/segment_pair_intersector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_pair_intersector_tb
// Streams segment pairs into the intersector with random gaps and output
// stalls, predicts touch, parallel and saturation flags and the line crossing point per
// request, and compares every result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module segment_pair_intersector_tb;
	import spi_pkg::*;

	localparam int CB = 16;
	localparam int FB = 8;
	localparam int LAT = 41;
	localparam int N_RAND = 1430;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic        crosses;
		logic        parallel;
		logic        saturated;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [8*CB-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0] m_tuser;

	logic [8*CB-1:0] pair_q[$];
	crossing_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int hold_cnt = 0;
	bit calm = 1'b0;
	bit stim_done = 1'b0;

	segment_pair_intersector #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic orient_t orientation(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (v == 0) return ORI_COLL;
		return (v > 0) ? ORI_CW : ORI_CCW;
	endfunction

	function automatic bit in_box(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint xlo, xhi, ylo, yhi;
		xlo = (px < rx) ? px : rx;
		xhi = (px < rx) ? rx : px;
		ylo = (py < ry) ? py : ry;
		yhi = (py < ry) ? ry : py;
		return qx >= xlo && qx <= xhi && qy >= ylo && qy <= yhi;
	endfunction

	// truncating fixed-point quotient, clamped to 32-bit signed
	function automatic logic [31:0] fix_quotient(logic signed [127:0] num, longint den,
			ref bit sat);
		logic signed [127:0] q;
		q = (num <<< FB) / 128'(signed'(den));
		if (q > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (q < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return q[31:0];
	endfunction

	function automatic crossing_t predict_crossing(logic [8*CB-1:0] d);
		longint c[8];
		orient_t o1, o2, o3, o4;
		longint dx12, dy12, dx34, dy34, det1, det2, den;
		logic signed [127:0] xn, yn;
		bit sat;
		crossing_t r;
		for (int i = 0; i < 8; i++) c[i] = longint'(signed'(d[i*CB +: CB]));
		o1 = orientation(c[0], c[1], c[2], c[3], c[4], c[5]);
		o2 = orientation(c[0], c[1], c[2], c[3], c[6], c[7]);
		o3 = orientation(c[4], c[5], c[6], c[7], c[0], c[1]);
		o4 = orientation(c[4], c[5], c[6], c[7], c[2], c[3]);
		r = '0;
		r.crosses = (o1 != o2 && o3 != o4)
			|| (o1 == ORI_COLL && in_box(c[0], c[1], c[4], c[5], c[2], c[3]))
			|| (o2 == ORI_COLL && in_box(c[0], c[1], c[6], c[7], c[2], c[3]))
			|| (o3 == ORI_COLL && in_box(c[4], c[5], c[0], c[1], c[6], c[7]))
			|| (o4 == ORI_COLL && in_box(c[4], c[5], c[2], c[3], c[6], c[7]));
		dx12 = c[0] - c[2];
		dy12 = c[1] - c[3];
		dx34 = c[4] - c[6];
		dy34 = c[5] - c[7];
		det1 = c[0] * c[3] - c[1] * c[2];
		det2 = c[4] * c[7] - c[5] * c[6];
		den = dx12 * dy34 - dy12 * dx34;
		r.parallel = (den == 0);
		sat = 1'b0;
		if (den != 0) begin
			xn = 128'(signed'(det1)) * 128'(signed'(dx34)) - 128'(signed'(dx12)) * 128'(signed'(det2));
			yn = 128'(signed'(det1)) * 128'(signed'(dy34)) - 128'(signed'(dy12)) * 128'(signed'(det2));
			r.px = fix_quotient(xn, den, sat);
			r.py = fix_quotient(yn, den, sat);
		end
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic [8*CB-1:0] pack_pair(int v[8]);
		logic [8*CB-1:0] d;
		for (int i = 0; i < 8; i++) d[i*CB +: CB] = v[i][CB-1:0];
		return d;
	endfunction

	function automatic int rand_coord(int span);
		int m;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) : -32768 + $urandom_range(0, 3);
			1: return int'($urandom_range(0, 65535)) - 32768;
			default: begin
				m = span;
				return int'($urandom_range(0, 2 * m)) - m;
			end
		endcase
	endfunction

	initial begin
		int v[8];
		int k, sx, sy, span;
		// directed: extremes, crossings, touching ends, collinear overlap, parallel,
		// degenerate points, saturating crossing point
		pair_q.push_back(pack_pair('{0, 0, 0, 0, 0, 0, 0, 0}));
		pair_q.push_back(pack_pair('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}));
		pair_q.push_back(pack_pair('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
		pair_q.push_back(pack_pair('{-32768, -32768, -32768, -32768, 0, 0, 1, 1}));
		pair_q.push_back(pack_pair('{0, 0, 10, 10, 0, 10, 10, 0}));
		pair_q.push_back(pack_pair('{0, 0, 10, 0, 10, 0, 20, 5}));
		pair_q.push_back(pack_pair('{0, 0, 10, 0, 5, 0, 20, 0}));
		pair_q.push_back(pack_pair('{0, 0, 10, 0, 11, 0, 20, 0}));
		pair_q.push_back(pack_pair('{0, 0, 10, 0, 0, 1, 10, 1}));
		pair_q.push_back(pack_pair('{0, 0, 10, 10, 5, 5, 5, 5}));
		pair_q.push_back(pack_pair('{0, 0, 10, 10, 6, 5, 6, 5}));
		pair_q.push_back(pack_pair('{0, 0, 1, 0, 0, 0, 1, 1}));
		pair_q.push_back(pack_pair('{-32768, 0, 32767, 1, -32768, 1, 32767, 0}));
		pair_q.push_back(pack_pair('{-32768, -32768, 32767, -32767, -32768, -32767, 32767, -32766}));
		pair_q.push_back(pack_pair('{32767, -32768, 32766, -32768, -32768, 32767, -32767, 32766}));
		pair_q.push_back(pack_pair('{1, 2, 3, 7, -4, 9, 8, -6}));
		pair_q.push_back(pack_pair('{0, 0, 3, 1, 0, 1, 3, 0}));
		pair_q.push_back(pack_pair('{-1, -1, -3, -2, 5, 5, -7, -9}));
		for (int i = 0; i < N_RAND; i++) begin
			span = $urandom_range(0, 3) == 0 ? 32767 : 64;
			k = $urandom_range(0, 9);
			for (int j = 0; j < 8; j++) v[j] = rand_coord(span);
			if (k == 0) begin
				// parallel: B offset of A's direction
				sx = $urandom_range(0, 200) - 100;
				sy = $urandom_range(0, 200) - 100;
				v[4] = v[0] + sx; v[5] = v[1] + sy;
				v[6] = v[2] + sx; v[7] = v[3] + sy;
			end else if (k == 1) begin
				// shared endpoint
				v[4] = v[2]; v[5] = v[3];
			end else if (k == 2) begin
				// collinear on one horizontal line
				v[1] = v[0]; v[3] = v[0]; v[5] = v[0]; v[7] = v[0];
			end else if (k == 3) begin
				v[2] = v[0]; v[3] = v[1];
			end
			pair_q.push_back(pack_pair(v));
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_q.push_back(predict_crossing(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (pair_q.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pair_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
					if (pair_q.size() == 0) stim_done <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		crossing_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request pending");
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (m_tdata[31:0] !== e.px) begin
						$error("point_x exp %h got %h", e.px, m_tdata[31:0]); errors++;
					end
					if (m_tdata[63:32] !== e.py) begin
						$error("point_y exp %h got %h", e.py, m_tdata[63:32]); errors++;
					end
					if (m_tuser[0] !== e.crosses) begin
						$error("crosses exp %b got %b", e.crosses, m_tuser[0]); errors++;
					end
					if (m_tuser[1] !== e.parallel) begin
						$error("parallel exp %b got %b", e.parallel, m_tuser[1]); errors++;
					end
					if (m_tuser[2] !== e.saturated) begin
						$error("saturated exp %b got %b", e.saturated, m_tuser[2]); errors++;
					end
				end
			end
			if (hold_cnt > 0) m_tready <= 1'b0;
			else m_tready <= calm || ($urandom_range(0, 99) >= 20);
		end
	end

	// hold off the receiver once for a long stretch; later run a calm window
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 300) hold_cnt <= 200;
		else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
		calm <= (cycles >= 800 && cycles < 1200);
	end

	initial begin
		int tail;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_done && !s_tvalid && expected_q.size() == 0) && cycles < LIMIT)
			@(posedge clk);
		tail = 0;
		while (tail < 2 * LAT && cycles < LIMIT) begin
			@(posedge clk);
			tail++;
		end
		if (cycles >= LIMIT) begin
			$display("Some tests failed");
		end else if (errors == 0 && expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// File: segment_pair_intersector.f
rtl/core/spi_pkg.sv
rtl/core/spi_fixdiv.sv
rtl/core/segment_pair_intersector.sv
dv/segment_pair_intersector_tb.sv
